@@ hdl/reader_frame_decoder_macros.svh @@
// Assertion macros shared by the reader frame decoder RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef READER_FRAME_DECODER_MACROS_SVH
`define READER_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define RFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/rfd_pkg.sv @@
// Shared types and constants for the reader frame decoder.
// No dependencies; rfd_frame_check, rfd_out_stage and the top level import this package.
package rfd_pkg;

	localparam int MAX_DATAGRAM_DEF = 128;

	localparam logic [7:0] START_MARKER_RST = 8'h02;
	localparam logic [7:0] END_MARKER_RST   = 8'h03;

	// Configuration register indexes.
	localparam logic CFG_START_MARKER = 1'b0;
	localparam logic CFG_END_MARKER   = 1'b1;

	localparam int MIN_FRAME_BYTES = 7;
	localparam int FRAME_OVERHEAD  = 6;
	localparam int FIRST_DATA_POS  = 5;
	localparam int LEN_POS         = 3;
	localparam int STATUS_POS      = 4;

	typedef enum logic {
		KIND_DATA    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		V_OK     = 3'd0,
		V_SHORT  = 3'd1,
		V_START  = 3'd2,
		V_LENGTH = 3'd3,
		V_END    = 3'd4,
		V_CHECK  = 3'd5
	} verdict_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		verdict_t   verdict;
	} result_t;

endpackage

@@ hdl/rfd_in_stage.sv @@
// Input register of the reader frame decoder: holds one received byte.
// No package dependencies; the stream handshake is plain valid/ready.
module rfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tlast,   // end_of_datagram
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

@@ hdl/rfd_frame_check.sv @@
// Frame state and per-byte checking logic of the reader frame decoder.
// Depends on rfd_pkg and reader_frame_decoder_macros.svh.
`include "reader_frame_decoder_macros.svh"

module rfd_frame_check #(
	parameter int MAX_DATAGRAM = rfd_pkg::MAX_DATAGRAM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      rx_byte,
	input  logic            last,
	input  logic [7:0]      start_marker,
	input  logic [7:0]      end_marker,
	output logic            has_result,
	output rfd_pkg::result_t result
);
	import rfd_pkg::*;

	localparam logic [7:0] MaxPos = 8'(MAX_DATAGRAM);

	logic [7:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] len_q;
	logic [7:0] status_q;
	logic [7:0] check_q;
	verdict_t   first_err_q;

	verdict_t   err_eff;
	verdict_t   verdict;
	logic [8:0] total;
	logic [8:0] len_plus_ovh;
	logic [8:0] len_plus_three;
	logic [7:0] calc;
	logic       data_out;

	always_comb begin
		// A datagram that has run past the size limit is a length error
		// unless its start was already bad.
		err_eff = first_err_q;
		if (pos_q >= MaxPos && first_err_q == V_OK) begin
			err_eff = V_LENGTH;
		end
		total          = {1'b0, pos_q} + 9'd1;
		len_plus_ovh   = {1'b0, len_q} + 9'(FRAME_OVERHEAD);
		len_plus_three = {1'b0, len_q} + 9'(LEN_POS);
		calc           = xor_q ^ check_q;

		if (total < 9'(MIN_FRAME_BYTES)) begin
			verdict = V_SHORT;
		end else if (err_eff != V_OK) begin
			verdict = err_eff;
		end else if (len_q == 8'h00 || total != len_plus_ovh) begin
			verdict = V_LENGTH;
		end else if (rx_byte != end_marker) begin
			verdict = V_END;
		end else if (calc != check_q) begin
			verdict = V_CHECK;
		end else begin
			verdict = V_OK;
		end

		data_out = pos_q >= 8'(FIRST_DATA_POS) && pos_q < MaxPos &&
			{1'b0, pos_q} <= len_plus_three;
	end

	always_comb begin
		has_result = last || data_out;
		if (last) begin
			result.kind    = KIND_VERDICT;
			result.value   = status_q;
			result.verdict = verdict;
		end else begin
			result.kind    = KIND_DATA;
			result.value   = rx_byte;
			result.verdict = V_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 8'h00;
			xor_q       <= 8'h00;
			len_q       <= 8'h00;
			status_q    <= 8'h00;
			check_q     <= 8'h00;
			first_err_q <= V_OK;
		end else if (advance) begin
			if (last) begin
				pos_q       <= 8'h00;
				xor_q       <= 8'h00;
				len_q       <= 8'h00;
				status_q    <= 8'h00;
				check_q     <= 8'h00;
				first_err_q <= V_OK;
			end else begin
				if (pos_q == 8'h00) begin
					first_err_q <= (rx_byte != start_marker) ? V_START : err_eff;
				end else begin
					first_err_q <= err_eff;
					xor_q       <= xor_q ^ rx_byte;
				end
				if (pos_q == 8'(LEN_POS)) begin
					len_q <= rx_byte;
				end
				if (pos_q == 8'(STATUS_POS)) begin
					status_q <= rx_byte;
				end
				check_q <= rx_byte;
				if (pos_q != 8'hFF) begin
					pos_q <= pos_q + 8'd1;
				end
			end
		end
	end

	`RFD_ASSERT_NEXT(a_clear_after_last, advance && last,
		pos_q == 8'h00 && first_err_q == V_OK, "frame state not cleared after last byte")
	`RFD_ASSERT_NOW(a_err_codes, 1'b1,
		first_err_q == V_OK || first_err_q == V_START || first_err_q == V_LENGTH,
		"unexpected stored error code")
	`RFD_ASSERT_NOW(a_no_early_data, advance && has_result && !last,
		pos_q >= 8'(FIRST_DATA_POS), "data byte emitted from frame header")

endmodule

@@ hdl/rfd_out_stage.sv @@
// Result register of the reader frame decoder and its stream handshake.
// Depends on rfd_pkg for the result type.
module rfd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rfd_pkg::result_t result,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,  // [7:0] value, [10:8] verdict, [15:11] zero
	output logic             m_tuser   // item_kind
);
	import rfd_pkg::*;

	result_t res_s2;

	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= result;
		end
	end

	assign m_tdata = {5'b00000, res_s2.verdict, res_s2.value};
	assign m_tuser = res_s2.kind;

endmodule

@@ hdl/reader_frame_decoder.sv @@
// Reader frame decoder top level: checks STX/ETX framed datagrams with XOR BCC.
// Depends on rfd_pkg, rfd_in_stage, rfd_frame_check, rfd_out_stage and the macros header.
//
//   channel  direction  payload
//   s_*      in         tdata[7:0] rx_byte, tlast end_of_datagram
//   m_*      out        tdata[7:0] value, tdata[10:8] verdict, tuser item_kind
//   cfg_*    in         cfg_index 0 start marker, 1 end marker, cfg_data 8 bit
//
// One byte per cycle unless m_tready stalls; bytes pass the input and result registers.
// The rate is set by the single pass of frame logic between input and result registers.
// Reset clears the frame state and loads start 0x02 and end 0x03 markers.
// A stalled m_tready holds the result register, then the input register, then s_tready.
`include "reader_frame_decoder_macros.svh"

module reader_frame_decoder #(
	parameter int MAX_DATAGRAM = rfd_pkg::MAX_DATAGRAM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // end_of_datagram
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] value, [10:8] verdict, [15:11] zero
	output logic        m_tuser,   // item_kind
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import rfd_pkg::*;

	logic       start_wr;
	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_free;
	logic       advance;
	logic       has_result;
	result_t    result;

	assign advance  = valid_s1 && out_free;
	assign start_wr = cfg_we && cfg_index == CFG_START_MARKER;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_we) begin
			if (start_wr) begin
				start_marker_q <= cfg_data;
			end
			if (cfg_index == CFG_END_MARKER) begin
				end_marker_q <= cfg_data;
			end
		end
	end

	rfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	rfd_frame_check #(
		.MAX_DATAGRAM (MAX_DATAGRAM)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.rx_byte      (byte_s1),
		.last         (last_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.has_result   (has_result),
		.result       (result)
	);

	rfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && has_result),
		.result   (result),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`RFD_ASSERT_NOW(a_data_verdict_zero, m_tvalid && m_tuser == KIND_DATA,
		m_tdata[10:8] == V_OK, "data item carries a verdict")
	`RFD_ASSERT_NOW(a_stall_reason, !s_tready, valid_s1 && m_tvalid && !m_tready,
		"input stalled without a full pipeline")
	`RFD_ASSERT_NEXT(a_last_gives_result, advance && last_s1,
		m_tvalid && m_tuser == KIND_VERDICT, "final byte did not yield a verdict")

endmodule
